// File: rtl/core/pt64_pkg.sv
// Package for the 64-bit primality tester.
// Holds the sequencer state type, base table and register constants. No dependencies.
package pt64_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRE,       // screen 2, 3, 5 and pick the method
    ST_WH_SQ,     // trial: div*div compare
    ST_WH_MOD,
    ST_MR_SPLIT,
    ST_MR_BASE,   // reduce base mod n
    ST_MR_MUL,    // x = x*a when the exponent bit is set
    ST_MR_SQA,    // a = a*a
    ST_MR_CHECK,
    ST_MR_SQR,
    ST_DONE
  } state_t;

  // Shared unit operation codes.
  typedef enum logic [1:0] {
    OP_MULMOD,
    OP_MOD
  } op_t;

  localparam logic [17:0] TRIAL_LIMIT_RESET = 18'd207936;
  localparam int MR_BASE_COUNT = 7;
  localparam logic [2:0] MR_LAST_BASE = 3'd6;
  localparam logic [0:0] REG_TRIAL_LIMIT = 1'b0;

  function automatic logic [63:0] mr_base(input logic [2:0] idx);
    logic [63:0] v;
    unique case (idx)
      3'd0: v = 64'd2;
      3'd1: v = 64'd325;
      3'd2: v = 64'd9375;
      3'd3: v = 64'd28178;
      3'd4: v = 64'd450775;
      3'd5: v = 64'd9780504;
      3'd6: v = 64'd1794265022;
      default: v = 64'd2;
    endcase
    return v;
  endfunction

  function automatic logic [3:0] wheel_gap(input logic [2:0] idx);
    logic [3:0] g;
    unique case (idx)
      3'd0: g = 4'd6;
      3'd1: g = 4'd4;
      3'd2: g = 4'd2;
      3'd3: g = 4'd4;
      3'd4: g = 4'd2;
      3'd5: g = 4'd4;
      3'd6: g = 4'd6;
      3'd7: g = 4'd2;
      default: g = 4'd2;
    endcase
    return g;
  endfunction

endpackage

// File: rtl/core/pt64_modunit.sv
// Shared bit-serial modular unit: (a*b) mod m or b mod m, one bit per cycle.
// Depends on pt64_pkg.
module pt64_modunit (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  pt64_pkg::op_t     op,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  input  logic [63:0]       m,
  output logic              done,
  output logic [63:0]       result
);

  logic        busy;
  logic [6:0]  cnt;
  pt64_pkg::op_t op_r;
  logic [63:0] ar, br, mr, acc;
  logic [64:0] dbl, dsub, addv, asub;
  logic [63:0] acc_d, acc_next;

  // mul: acc = 2acc (+a); mod: acc = 2acc + bit of b. Each add has its own subtract.
  always_comb begin
    dbl   = {acc, 1'b0};
    dsub  = dbl - {1'b0, mr};
    acc_d = (dbl >= {1'b0, mr}) ? dsub[63:0] : dbl[63:0];
    if (op_r == pt64_pkg::OP_MOD) begin
      addv = {1'b0, acc_d} + {64'd0, br[63]};
    end else begin
      addv = {1'b0, acc_d} + (br[63] ? {1'b0, ar} : 65'd0);
    end
    asub     = addv - {1'b0, mr};
    acc_next = (addv >= {1'b0, mr}) ? asub[63:0] : addv[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= 7'd0;
        op_r <= op;
        ar   <= a;
        br   <= b;
        mr   <= m;
        acc  <= '0;
      end else if (busy) begin
        acc <= acc_next;
        br  <= {br[62:0], 1'b0};
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = acc;

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without busy");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    (busy && cnt != 7'd63) |=> busy) else $error("unit dropped busy early");
  a_result_reduced: assert property (@(posedge clk) disable iff (rst)
    done |-> (result < mr)) else $error("result not reduced");
`endif

endmodule

// File: rtl/core/prime_test_64bit_top.sv
// Top level of the 64-bit primality tester: sequencer, config register, stream ports.
// Depends on pt64_pkg and pt64_modunit.
//
// channel | dir | beat
// s_axis  | in  | tdata[63:0] = candidate
// m_axis  | out | tdata[7:0]  = is_prime in bit 0, rest zero
// apb     | in  | trial_limit at 0x0
//
// All modular arithmetic runs on one 64-step shift-add modular unit.
// ST_PRE screens multiples of 2 by bit 0, of 3 and 5 by a mod-15 digit sum.
// Trial division uses one unit call per divisor.
// Miller-Rabin needs at most 126 unit calls per base.
// Reset is synchronous and restores trial_limit. s_tready is low from accept until
// the result beat is taken.
module prime_test_64bit_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [63:0] candidate
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [0] is_prime, [7:1] zero
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pt64_pkg::state_t state, state_next;
  logic [17:0] trial_limit;
  logic [63:0] n, d, x, e, base_a;
  logic [9:0]  div;
  logic [19:0] div_sq;
  logic [5:0]  s, r;
  logic [2:0]  bidx, gidx;
  logic        answer, pending, go;
  logic        u_start, u_done;
  pt64_pkg::op_t u_op;
  logic [63:0] u_a, u_b, u_m, u_res;
  logic [63:0] n_less;
  logic [3:0]  m15;
  logic        div3, div5, screen_out, last_base;

  // n mod 15 from a nibble sum (16 = 1 mod 15); 15 stands for 0.
  function automatic logic [3:0] mod15(input logic [63:0] v);
    logic [4:0] p [8];
    logic [5:0] q [4];
    logic [7:0] t;
    logic [4:0] f;
    logic [4:0] g;
    for (int i = 0; i < 8; i++) p[i] = {1'b0, v[8*i +: 4]} + {1'b0, v[8*i+4 +: 4]};
    for (int i = 0; i < 4; i++) q[i] = {1'b0, p[2*i]} + {1'b0, p[2*i+1]};
    t = ({2'b00, q[0]} + {2'b00, q[1]}) + ({2'b00, q[2]} + {2'b00, q[3]});
    f = {1'b0, t[7:4]} + {1'b0, t[3:0]};
    g = {4'd0, f[4]} + {1'b0, f[3:0]};
    return g[3:0];
  endfunction

  assign pready = 1'b1;
  assign prdata = (paddr[2] == pt64_pkg::REG_TRIAL_LIMIT) ? {14'd0, trial_limit} : 32'd0;
  assign n_less = n - 64'd1;
  assign div_sq = {10'd0, div} * {10'd0, div};
  assign m15    = mod15(n);
  assign div3   = (m15 == 4'd0) || (m15 == 4'd3) || (m15 == 4'd6) || (m15 == 4'd9) ||
                  (m15 == 4'd12) || (m15 == 4'd15);
  assign div5   = (m15 == 4'd0) || (m15 == 4'd5) || (m15 == 4'd10) || (m15 == 4'd15);
  assign screen_out = (n < 64'd2) || (n == 64'd2) || (n == 64'd3) || (n == 64'd5) ||
                      !n[0] || div3 || div5;
  assign last_base = (bidx == pt64_pkg::MR_LAST_BASE);

  always_ff @(posedge clk) begin
    if (rst) begin
      trial_limit <= pt64_pkg::TRIAL_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == pt64_pkg::REG_TRIAL_LIMIT) begin
      trial_limit <= pwdata[17:0];
    end
  end

  pt64_modunit u_mod (
    .clk(clk), .rst(rst), .start(u_start), .op(u_op),
    .a(u_a), .b(u_b), .m(u_m), .done(u_done), .result(u_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= pt64_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
      pending  <= 1'b0;
    end else begin
      state   <= state_next;
      pending <= u_start ? 1'b1 : (u_done ? 1'b0 : pending);
      if (state == pt64_pkg::ST_DONE) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign s_tready = (state == pt64_pkg::ST_IDLE) && !m_tvalid;
  assign m_tdata  = {7'd0, answer};
  assign go       = !pending && !u_done;

  always_comb begin
    state_next = state;
    u_start = 1'b0;
    u_op = pt64_pkg::OP_MOD;
    u_a = x;
    u_b = n;
    u_m = n;
    unique case (state)
      pt64_pkg::ST_IDLE:
        if (s_tvalid && s_tready) state_next = pt64_pkg::ST_PRE;
      pt64_pkg::ST_PRE: begin
        if (screen_out) state_next = pt64_pkg::ST_DONE;
        else if (n <= {46'd0, trial_limit}) state_next = pt64_pkg::ST_WH_SQ;
        else state_next = pt64_pkg::ST_MR_SPLIT;
      end
      pt64_pkg::ST_WH_SQ: begin
        if ({44'd0, div_sq} > n) state_next = pt64_pkg::ST_DONE;
        else state_next = pt64_pkg::ST_WH_MOD;
      end
      pt64_pkg::ST_WH_MOD: begin
        u_b = n; u_m = {54'd0, div}; u_start = go;
        if (u_done) state_next = (u_res == 64'd0) ? pt64_pkg::ST_DONE : pt64_pkg::ST_WH_SQ;
      end
      pt64_pkg::ST_MR_SPLIT:
        if (d[0]) state_next = pt64_pkg::ST_MR_BASE;
      pt64_pkg::ST_MR_BASE: begin
        u_b = pt64_pkg::mr_base(bidx); u_m = n; u_start = go;
        if (u_done) begin
          if (u_res != 64'd0) state_next = pt64_pkg::ST_MR_MUL;
          else if (last_base) state_next = pt64_pkg::ST_DONE;
        end
      end
      pt64_pkg::ST_MR_MUL: begin
        u_op = pt64_pkg::OP_MULMOD; u_a = x; u_b = base_a; u_start = go && e[0];
        if (!e[0] || u_done) state_next = pt64_pkg::ST_MR_SQA;
      end
      pt64_pkg::ST_MR_SQA: begin
        u_op = pt64_pkg::OP_MULMOD; u_a = base_a; u_b = base_a;
        if (e[63:1] == 63'd0) begin
          state_next = pt64_pkg::ST_MR_CHECK;
        end else begin
          u_start = go;
          if (u_done) state_next = pt64_pkg::ST_MR_MUL;
        end
      end
      pt64_pkg::ST_MR_CHECK: begin
        if (x == 64'd1 || x == n_less)
          state_next = last_base ? pt64_pkg::ST_DONE : pt64_pkg::ST_MR_BASE;
        else if (r >= s) state_next = pt64_pkg::ST_DONE;
        else state_next = pt64_pkg::ST_MR_SQR;
      end
      pt64_pkg::ST_MR_SQR: begin
        u_op = pt64_pkg::OP_MULMOD; u_a = x; u_b = x; u_start = go;
        if (u_done) begin
          if (u_res == n_less)
            state_next = last_base ? pt64_pkg::ST_DONE : pt64_pkg::ST_MR_BASE;
          else if (r + 6'd1 >= s) state_next = pt64_pkg::ST_DONE;
        end
      end
      pt64_pkg::ST_DONE: state_next = pt64_pkg::ST_IDLE;
      default: state_next = pt64_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state)
      pt64_pkg::ST_IDLE:
        if (s_tvalid && s_tready) n <= s_tdata;
      pt64_pkg::ST_PRE: begin
        if (n == 64'd2 || n == 64'd3 || n == 64'd5) answer <= 1'b1;
        else answer <= !screen_out;
        d <= n_less; s <= 6'd0; div <= 10'd7; gidx <= 3'd1; bidx <= 3'd0;
      end
      pt64_pkg::ST_WH_MOD:
        if (u_done) begin
          if (u_res == 64'd0) answer <= 1'b0;
          div  <= div + {6'd0, pt64_pkg::wheel_gap(gidx)};
          gidx <= gidx + 3'd1;
        end
      pt64_pkg::ST_MR_SPLIT:
        if (!d[0]) begin
          d <= {1'b0, d[63:1]}; s <= s + 6'd1;
        end
      pt64_pkg::ST_MR_BASE:
        if (u_done) begin
          if (u_res == 64'd0) begin
            bidx <= bidx + 3'd1;
          end else begin
            base_a <= u_res; x <= 64'd1; e <= d; r <= 6'd1;
          end
        end
      pt64_pkg::ST_MR_MUL:
        if (e[0] && u_done) x <= u_res;
      pt64_pkg::ST_MR_SQA:
        if (u_done) begin
          base_a <= u_res; e <= {1'b0, e[63:1]};
        end
      pt64_pkg::ST_MR_CHECK: begin
        if (x == 64'd1 || x == n_less) bidx <= bidx + 3'd1;
        else if (r >= s) answer <= 1'b0;
      end
      pt64_pkg::ST_MR_SQR:
        if (u_done) begin
          x <= u_res; r <= r + 6'd1;
          if (u_res == n_less) bidx <= bidx + 3'd1;
          else if (r + 6'd1 >= s) answer <= 1'b0;
        end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == pt64_pkg::ST_IDLE)) else $error("ready outside idle");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("accepted while result pending");
  a_data_stable: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> $stable(m_tdata)) else $error("result beat changed");
`endif

endmodule
